[hw/rtl/radix_integer_to_ascii_assert.svh]
// assertion macros for the radix integer to ascii converter
// expects clk and rst_n in the scope of the including module
`ifndef RADIX_INTEGER_TO_ASCII_ASSERT_SVH
`define RADIX_INTEGER_TO_ASCII_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define RITOA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent holds in the following cycle
`define RITOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ritoa_pkg.sv]
// shared types, sizes and character helpers for the radix integer to ascii converter
// no dependencies
package ritoa_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int DIGIT_SLOTS = 32;
  localparam int MAX_OUT     = 32;
  localparam int SLOTS       = (DIGIT_SLOTS < MAX_OUT) ? DIGIT_SLOTS : MAX_OUT;

  // quotient bits resolved per divider cycle; VALUE_BITS must be a multiple of it
  localparam int DIV_STEP    = 4;
  localparam int DIV_CYCLES  = VALUE_BITS / DIV_STEP;
  localparam int STEP_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int IDX_W       = $clog2(SLOTS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_READ,
    ST_EMIT,
    ST_ZERO
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                       input logic upper);
    logic [CHAR_W-1:0] letter_base;
    letter_base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
    if (d < DIGIT_W'(10)) begin
      return ASCII_ZERO + CHAR_W'(d);
    end
    return letter_base + CHAR_W'(d - DIGIT_W'(10));
  endfunction

endpackage

[hw/rtl/radix_integer_to_ascii.sv]
// radix integer to ascii converter, top level
// depends on ritoa_pkg and radix_integer_to_ascii_assert.svh
//
// Usage: raise start with in_number, in_radix, in_signed_mode and in_upper_case
// while busy is low; that beat is taken at the clock edge. busy then stays high
// until the text is out. Characters come most significant first on
// out_character, one per out_valid strobe, with out_last_char on the final one.
// A base outside 2..36, or a zero value, gives the single character '0'. In
// signed mode with base ten a negative value gets a leading '-' and its full
// magnitude.
// Timing: one shared restoring divider resolves four quotient bits a cycle, so
// each digit takes a full pass over all VALUE_BITS of the value. Output runs
// through the digit memory's registered read port, a read state and an emit
// state per character, with a sign state before them for a '-'. busy falls
// after the last character; a new beat is taken only once busy is low. The
// receiver cannot stall.
// Reset (synchronous, rst_n low) returns the sequencer to idle with busy low;
// no clearing pass is needed.
module radix_integer_to_ascii (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ritoa_pkg::VALUE_BITS-1:0]     in_number,
  input  logic [ritoa_pkg::RADIX_W-1:0]        in_radix,
  input  logic                                 in_signed_mode,
  input  logic                                 in_upper_case,
  output logic                                 out_valid,
  output logic [ritoa_pkg::CHAR_W-1:0]         out_character,
  output logic                                 out_last_char
);

  `include "radix_integer_to_ascii_assert.svh"

  ritoa_pkg::state_t state_r, state_nxt;

  logic [ritoa_pkg::VALUE_BITS-1:0] val_r, val_nxt;
  logic [ritoa_pkg::DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [ritoa_pkg::RADIX_W-1:0]    base_r, base_nxt;
  logic [ritoa_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [ritoa_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [ritoa_pkg::CNT_W-1:0]      cap_r, cap_nxt;
  logic                             minus_r, minus_nxt;
  logic                             upper_r, upper_nxt;

  logic [ritoa_pkg::DIGIT_W-1:0]    digit_mem [ritoa_pkg::SLOTS];
  logic [ritoa_pkg::DIGIT_W-1:0]    rd_data_r;
  logic [ritoa_pkg::IDX_W-1:0]      rd_idx;
  logic                             mem_we;

  logic                             accept;
  logic                             trivial;
  logic                             neg;
  logic [ritoa_pkg::VALUE_BITS-1:0] magnitude;

  logic [ritoa_pkg::DIGIT_W:0]      trial;
  logic [ritoa_pkg::DIGIT_W-1:0]    rem_step;
  logic [ritoa_pkg::VALUE_BITS-1:0] val_step;
  logic                             digit_done;
  logic                             conv_done;

  assign accept  = start && !busy;
  assign trivial = (in_radix < ritoa_pkg::RADIX_MIN) || (in_radix > ritoa_pkg::RADIX_MAX) ||
                   (in_number == '0);
  assign neg     = in_signed_mode && (in_radix == ritoa_pkg::RADIX_DEC) &&
                   in_number[ritoa_pkg::VALUE_BITS-1];
  assign magnitude = neg ? (~in_number + ritoa_pkg::VALUE_BITS'(1)) : in_number;

  // restoring division, DIV_STEP quotient bits per cycle; quotient shifts into val
  always_comb begin
    rem_step = rem_r;
    val_step = val_r;
    trial    = '0;
    for (int i = 0; i < ritoa_pkg::DIV_STEP; i++) begin
      trial    = {rem_step, val_step[ritoa_pkg::VALUE_BITS-1]};
      val_step = {val_step[ritoa_pkg::VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, base_r}) begin
        rem_step    = ritoa_pkg::DIGIT_W'(trial - {1'b0, base_r});
        val_step[0] = 1'b1;
      end else begin
        rem_step = trial[ritoa_pkg::DIGIT_W-1:0];
      end
    end
  end

  assign digit_done = (step_r == ritoa_pkg::STEP_W'(ritoa_pkg::DIV_CYCLES - 1));
  assign conv_done  = (val_step == '0) || ((count_r + ritoa_pkg::CNT_W'(1)) == cap_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ritoa_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = trivial ? ritoa_pkg::ST_ZERO : ritoa_pkg::ST_DIVIDE;
        end
      end
      ritoa_pkg::ST_DIVIDE: begin
        if (digit_done && conv_done) begin
          state_nxt = minus_r ? ritoa_pkg::ST_SIGN : ritoa_pkg::ST_READ;
        end
      end
      ritoa_pkg::ST_SIGN: state_nxt = ritoa_pkg::ST_READ;
      ritoa_pkg::ST_READ: state_nxt = ritoa_pkg::ST_EMIT;
      ritoa_pkg::ST_EMIT: begin
        state_nxt = (count_r == ritoa_pkg::CNT_W'(1)) ? ritoa_pkg::ST_IDLE
                                                       : ritoa_pkg::ST_READ;
      end
      ritoa_pkg::ST_ZERO: state_nxt = ritoa_pkg::ST_IDLE;
      default: state_nxt = ritoa_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy          = (state_r != ritoa_pkg::ST_IDLE);
    out_valid     = 1'b0;
    out_character = ritoa_pkg::ASCII_ZERO;
    out_last_char = 1'b0;
    mem_we        = 1'b0;
    unique case (state_r)
      ritoa_pkg::ST_IDLE, ritoa_pkg::ST_READ: begin
      end
      ritoa_pkg::ST_DIVIDE: mem_we = digit_done;
      ritoa_pkg::ST_SIGN: begin
        out_valid     = 1'b1;
        out_character = ritoa_pkg::ASCII_MINUS;
      end
      ritoa_pkg::ST_EMIT: begin
        out_valid     = 1'b1;
        out_character = ritoa_pkg::digit_to_ascii(rd_data_r, upper_r);
        out_last_char = (count_r == ritoa_pkg::CNT_W'(1));
      end
      ritoa_pkg::ST_ZERO: begin
        out_valid     = 1'b1;
        out_last_char = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    val_nxt   = val_r;
    rem_nxt   = rem_r;
    base_nxt  = base_r;
    step_nxt  = step_r;
    count_nxt = count_r;
    cap_nxt   = cap_r;
    minus_nxt = minus_r;
    upper_nxt = upper_r;
    unique case (state_r)
      ritoa_pkg::ST_IDLE: begin
        if (accept) begin
          val_nxt   = magnitude;
          rem_nxt   = '0;
          base_nxt  = in_radix;
          step_nxt  = '0;
          count_nxt = '0;
          minus_nxt = neg && !trivial;
          upper_nxt = in_upper_case;
          cap_nxt   = ritoa_pkg::CNT_W'(ritoa_pkg::SLOTS) -
                      ritoa_pkg::CNT_W'(neg && !trivial);
        end
      end
      ritoa_pkg::ST_DIVIDE: begin
        val_nxt = val_step;
        if (digit_done) begin
          rem_nxt   = '0;
          step_nxt  = '0;
          count_nxt = count_r + ritoa_pkg::CNT_W'(1);
        end else begin
          rem_nxt  = rem_step;
          step_nxt = step_r + ritoa_pkg::STEP_W'(1);
        end
      end
      ritoa_pkg::ST_SIGN: minus_nxt = 1'b0;
      ritoa_pkg::ST_READ: begin
      end
      ritoa_pkg::ST_EMIT: count_nxt = count_r - ritoa_pkg::CNT_W'(1);
      ritoa_pkg::ST_ZERO: count_nxt = '0;
      default: begin
      end
    endcase
  end

  // next digit to show sits one below the count
  assign rd_idx = ritoa_pkg::IDX_W'(count_r - ritoa_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[count_r[ritoa_pkg::IDX_W-1:0]] <= rem_step;
    end
    rd_data_r <= digit_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ritoa_pkg::ST_IDLE;
      count_r <= '0;
      minus_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      minus_r <= minus_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    rem_r   <= rem_nxt;
    base_r  <= base_nxt;
    step_r  <= step_nxt;
    cap_r   <= cap_nxt;
    upper_r <= upper_nxt;
  end

  `RITOA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy,
                     "accepted beat did not raise busy")
  `RITOA_ASSERT_NEXT(a_last_frees, out_valid && out_last_char, !busy,
                     "still busy after last char")
  `RITOA_ASSERT_SAME(a_strobe_busy, out_valid, busy, "character strobed while idle")
  `RITOA_ASSERT_SAME(a_rem_below_base, state_r == ritoa_pkg::ST_DIVIDE, rem_r < base_r,
                     "partial remainder not below base")

endmodule
